[design/pfx_pkg.sv]
`timescale 1ns / 1ps

package pfx_pkg;

  localparam int unsigned UPC_W = 5;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam logic [UPC_W-1:0] A_FETCH  = 5'd0;
  localparam logic [UPC_W-1:0] A_DECODE = 5'd1;
  localparam logic [UPC_W-1:0] A_DIGIT  = 5'd2;
  localparam logic [UPC_W-1:0] A_BAD    = 5'd3;
  localparam logic [UPC_W-1:0] A_POP1   = 5'd4;
  localparam logic [UPC_W-1:0] A_POP2   = 5'd5;
  localparam logic [UPC_W-1:0] A_POP3   = 5'd6;
  localparam logic [UPC_W-1:0] A_ADD    = 5'd7;
  localparam logic [UPC_W-1:0] A_SUB    = 5'd8;
  localparam logic [UPC_W-1:0] A_MUL    = 5'd9;
  localparam logic [UPC_W-1:0] A_MULS   = 5'd10;
  localparam logic [UPC_W-1:0] A_DIV    = 5'd11;
  localparam logic [UPC_W-1:0] A_DIVS   = 5'd12;
  localparam logic [UPC_W-1:0] A_DIVF   = 5'd13;
  localparam logic [UPC_W-1:0] A_DIVZ   = 5'd14;
  localparam logic [UPC_W-1:0] A_PUSH   = 5'd15;
  localparam logic [UPC_W-1:0] A_EPOP   = 5'd16;
  localparam logic [UPC_W-1:0] A_ELOAD  = 5'd17;
  localparam logic [UPC_W-1:0] A_EMIT   = 5'd18;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_DIGIT, OP_BAD, OP_POP, OP_POPB, OP_LOADA, OP_LOADB,
    OP_ADD, OP_SUB, OP_MUL, OP_MULS, OP_DIVINIT, OP_DIVSTEP, OP_DIVFIN,
    OP_DIVZ, OP_PUSH, OP_EMIT
  } uop_e;

  typedef enum logic [3:0] {
    J_NEXT, J_GOTO, J_IN, J_CLASS, J_OPER, J_LAST, J_LOOP, J_ZERO, J_OUT
  } jmp_e;

  typedef enum logic [1:0] {
    AR_ADD, AR_SUB, AR_MUL, AR_DIV
  } arith_e;

  typedef struct packed {
    uop_e             op;
    jmp_e             jmp;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic   in_valid;
    logic   last;
    logic   is_digit;
    logic   is_oper;
    arith_e oper;
    logic   b_zero;
    logic   div_done;
    logic   out_free;
  } status_t;

  function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    case (addr)
      A_FETCH:  w = '{OP_LATCH,   J_IN,    A_FETCH};
      A_DECODE: w = '{OP_NOP,     J_CLASS, A_FETCH};
      A_DIGIT:  w = '{OP_DIGIT,   J_GOTO,  A_PUSH};
      A_BAD:    w = '{OP_BAD,     J_LAST,  A_EPOP};
      A_POP1:   w = '{OP_POP,     J_NEXT,  A_FETCH};
      A_POP2:   w = '{OP_POPB,    J_NEXT,  A_FETCH};
      A_POP3:   w = '{OP_LOADA,   J_OPER,  A_FETCH};
      A_ADD:    w = '{OP_ADD,     J_GOTO,  A_PUSH};
      A_SUB:    w = '{OP_SUB,     J_GOTO,  A_PUSH};
      A_MUL:    w = '{OP_MUL,     J_NEXT,  A_FETCH};
      A_MULS:   w = '{OP_MULS,    J_GOTO,  A_PUSH};
      A_DIV:    w = '{OP_DIVINIT, J_ZERO,  A_DIVZ};
      A_DIVS:   w = '{OP_DIVSTEP, J_LOOP,  A_FETCH};
      A_DIVF:   w = '{OP_DIVFIN,  J_GOTO,  A_PUSH};
      A_DIVZ:   w = '{OP_DIVZ,    J_NEXT,  A_FETCH};
      A_PUSH:   w = '{OP_PUSH,    J_LAST,  A_EPOP};
      A_EPOP:   w = '{OP_POP,     J_NEXT,  A_FETCH};
      A_ELOAD:  w = '{OP_LOADB,   J_NEXT,  A_FETCH};
      A_EMIT:   w = '{OP_EMIT,    J_OUT,   A_FETCH};
      default:  w = '{OP_NOP,     J_GOTO,  A_FETCH};
    endcase
    return w;
  endfunction

endpackage

[design/pfx_ram.sv]
`timescale 1ns / 1ps

module pfx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pfx_seq.sv]
`timescale 1ns / 1ps

module pfx_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pfx_pkg::status_t       status_i,
  output pfx_pkg::uop_e          op_o
);

  logic [pfx_pkg::UPC_W-1:0] upc_q, upc_d;
  pfx_pkg::ctrl_t            cw;

  assign cw   = pfx_pkg::ucode(upc_q);
  assign op_o = cw.op;

  always_comb begin
    upc_d = upc_q;
    case (cw.jmp)
      pfx_pkg::J_NEXT: upc_d = upc_q + 1'b1;
      pfx_pkg::J_GOTO: upc_d = cw.target;
      pfx_pkg::J_IN: begin
        if (status_i.in_valid) upc_d = upc_q + 1'b1;
      end
      pfx_pkg::J_CLASS: begin
        if (status_i.is_digit) begin
          upc_d = pfx_pkg::A_DIGIT;
        end else if (status_i.is_oper) begin
          upc_d = pfx_pkg::A_POP1;
        end else begin
          upc_d = pfx_pkg::A_BAD;
        end
      end
      pfx_pkg::J_OPER: begin
        case (status_i.oper)
          pfx_pkg::AR_ADD: upc_d = pfx_pkg::A_ADD;
          pfx_pkg::AR_SUB: upc_d = pfx_pkg::A_SUB;
          pfx_pkg::AR_MUL: upc_d = pfx_pkg::A_MUL;
          pfx_pkg::AR_DIV: upc_d = pfx_pkg::A_DIV;
          default:         upc_d = pfx_pkg::A_FETCH;
        endcase
      end
      pfx_pkg::J_LAST: upc_d = status_i.last ? cw.target : pfx_pkg::A_FETCH;
      pfx_pkg::J_LOOP: begin
        if (status_i.div_done) upc_d = upc_q + 1'b1;
      end
      pfx_pkg::J_ZERO: upc_d = status_i.b_zero ? cw.target : upc_q + 1'b1;
      pfx_pkg::J_OUT: begin
        if (status_i.out_free) upc_d = cw.target;
      end
      default: upc_d = pfx_pkg::A_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= pfx_pkg::A_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[design/pfx_dp.sv]
`timescale 1ns / 1ps

module pfx_dp #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfx_pkg::uop_e    op_i,
  output pfx_pkg::status_t status_o,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DCW = pfx_pkg::DIV_CNT_W;

  logic [CW-1:0]  count_q, count_d, count_m1;
  logic           div0_q, div0_d, ovf_q, ovf_d, bad_q, bad_d;
  logic           popv_q, popv_d, mvalid_q, mvalid_d;
  logic [7:0]     sym_q, sym_d;
  logic           last_q, last_d;
  logic [31:0]    a_q, a_d, b_q, b_d, r_q, r_d;
  logic [63:0]    prod_q, prod_d;
  logic [31:0]    rem_q, rem_d, dv_q, dv_d;
  logic [47:0]    dq_q, dq_d;
  logic [DCW-1:0] cnt_q, cnt_d;
  logic           neg_q, neg_d;
  logic [39:0]    out_q, out_d;

  logic           ram_we, ram_re;
  logic [31:0]    ram_rdata, popped;
  logic           out_free, is_digit, is_oper;
  pfx_pkg::arith_e oper;
  logic [32:0]    sum, dif, shift;
  logic [33:0]    trial;
  logic [31:0]    mag_a, mag_b;

  assign count_m1 = count_q - 1'b1;
  assign popped   = popv_q ? ram_rdata : 32'd0;
  assign out_free = !mvalid_q || m_axis_tready;
  assign is_digit = (sym_q >= pfx_pkg::CH_ZERO) && (sym_q <= pfx_pkg::CH_NINE);
  assign is_oper  = (sym_q == pfx_pkg::CH_PLUS) || (sym_q == pfx_pkg::CH_MINUS) ||
                    (sym_q == pfx_pkg::CH_STAR) || (sym_q == pfx_pkg::CH_SLASH);

  always_comb begin
    case (sym_q)
      pfx_pkg::CH_PLUS:  oper = pfx_pkg::AR_ADD;
      pfx_pkg::CH_MINUS: oper = pfx_pkg::AR_SUB;
      pfx_pkg::CH_STAR:  oper = pfx_pkg::AR_MUL;
      default:           oper = pfx_pkg::AR_DIV;
    endcase
  end

  assign sum   = {a_q[31], a_q} + {b_q[31], b_q};
  assign dif   = {a_q[31], a_q} - {b_q[31], b_q};
  assign mag_a = a_q[31] ? (32'd0 - a_q) : a_q;
  assign mag_b = b_q[31] ? (32'd0 - b_q) : b_q;
  assign shift = {rem_q, dq_q[47]};
  assign trial = {1'b0, shift} - {2'b00, dv_q};

  always_comb begin
    count_d  = count_q;
    div0_d   = div0_q;
    ovf_d    = ovf_q;
    bad_d    = bad_q;
    popv_d   = popv_q;
    mvalid_d = mvalid_q;
    sym_d    = sym_q;
    last_d   = last_q;
    a_d      = a_q;
    b_d      = b_q;
    r_d      = r_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    dv_d     = dv_q;
    dq_d     = dq_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    out_d    = out_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;

    if (mvalid_q && m_axis_tready) mvalid_d = 1'b0;

    if (op_i == pfx_pkg::OP_POP || op_i == pfx_pkg::OP_POPB) begin
      popv_d = count_q != '0;
      if (count_q != '0) begin
        ram_re  = 1'b1;
        count_d = count_m1;
      end
    end

    case (op_i)
      pfx_pkg::OP_LATCH: begin
        if (s_axis_tvalid) begin
          sym_d  = s_axis_tdata;
          last_d = s_axis_tlast;
        end
      end
      pfx_pkg::OP_DIGIT: r_d = {12'd0, sym_q[3:0], 16'd0};
      pfx_pkg::OP_BAD:   bad_d = 1'b1;
      pfx_pkg::OP_POPB:  b_d = popped;
      pfx_pkg::OP_LOADA: a_d = popped;
      pfx_pkg::OP_LOADB: b_d = popped;
      pfx_pkg::OP_ADD: begin
        if (sum[32] != sum[31]) begin
          r_d = sum[32] ? pfx_pkg::Q_MIN : pfx_pkg::Q_MAX;
        end else begin
          r_d = sum[31:0];
        end
      end
      pfx_pkg::OP_SUB: begin
        if (dif[32] != dif[31]) begin
          r_d = dif[32] ? pfx_pkg::Q_MIN : pfx_pkg::Q_MAX;
        end else begin
          r_d = dif[31:0];
        end
      end
      pfx_pkg::OP_MUL: prod_d = $signed(a_q) * $signed(b_q);
      pfx_pkg::OP_MULS: begin
        if ((&prod_q[63:47]) || !(|prod_q[63:47])) begin
          r_d = prod_q[47:16];
        end else begin
          r_d = prod_q[63] ? pfx_pkg::Q_MIN : pfx_pkg::Q_MAX;
        end
      end
      pfx_pkg::OP_DIVINIT: begin
        dq_d  = {mag_a, 16'd0};
        dv_d  = mag_b;
        rem_d = '0;
        cnt_d = '0;
        neg_d = a_q[31] ^ b_q[31];
      end
      pfx_pkg::OP_DIVSTEP: begin
        if (!trial[33]) begin
          rem_d = trial[31:0];
        end else begin
          rem_d = shift[31:0];
        end
        dq_d  = {dq_q[46:0], !trial[33]};
        cnt_d = cnt_q + 1'b1;
      end
      pfx_pkg::OP_DIVFIN: begin
        if (neg_q) begin
          if ((dq_q[47:32] != '0) || (dq_q[31] && (dq_q[30:0] != '0))) begin
            r_d = pfx_pkg::Q_MIN;
          end else begin
            r_d = 32'd0 - dq_q[31:0];
          end
        end else if (dq_q[47:31] != '0) begin
          r_d = pfx_pkg::Q_MAX;
        end else begin
          r_d = dq_q[31:0];
        end
      end
      pfx_pkg::OP_DIVZ: begin
        r_d    = '0;
        div0_d = 1'b1;
      end
      pfx_pkg::OP_PUSH: begin
        if (count_q == CW'(STACK_DEPTH)) begin
          ovf_d = 1'b1;
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      pfx_pkg::OP_EMIT: begin
        if (out_free) begin
          out_d    = {5'd0, bad_q, ovf_q, div0_q, b_q};
          mvalid_d = 1'b1;
          count_d  = '0;
          div0_d   = 1'b0;
          ovf_d    = 1'b0;
          bad_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      div0_q   <= 1'b0;
      ovf_q    <= 1'b0;
      bad_q    <= 1'b0;
      popv_q   <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      div0_q   <= div0_d;
      ovf_q    <= ovf_d;
      bad_q    <= bad_d;
      popv_q   <= popv_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    last_q <= last_d;
    a_q    <= a_d;
    b_q    <= b_d;
    r_q    <= r_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    dq_q   <= dq_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  pfx_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (r_q),
    .re_i    (ram_re),
    .raddr_i (count_m1[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign status_o.in_valid = s_axis_tvalid;
  assign status_o.last     = last_q;
  assign status_o.is_digit = is_digit;
  assign status_o.is_oper  = is_oper;
  assign status_o.oper     = oper;
  assign status_o.b_zero   = b_q == '0;
  assign status_o.div_done = cnt_q == DCW'(pfx_pkg::DIV_STEPS - 1);
  assign status_o.out_free = out_free;

  assign s_axis_tready = op_i == pfx_pkg::OP_LATCH;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = out_q;

endmodule

[design/postfix_expression_evaluator_top.sv]
`timescale 1ns / 1ps

// Postfix expression evaluator over signed Q16.16 operands. One character
// is taken per beat on the slave side; tlast marks the end of an expression,
// and after it one result beat carries the popped value and the sticky
// divide-by-zero, stack-overflow and bad-symbol flags. Items are processed
// one at a time by a microcoded sequencer, so the time per beat depends on
// the character; divide is the slowest, with its 48-step restoring divider.
// The last beat of an expression also pops the result and may wait for the
// result register to drain. A new character is accepted while an earlier
// result still waits.

module postfix_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] value, [32] divide_by_zero,
                                     // [33] stack_overflow, [34] bad_symbol
);

  pfx_pkg::uop_e    op;
  pfx_pkg::status_t status;

  pfx_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  pfx_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[design/pfx_checker.sv]
`timescale 1ns / 1ps

module pfx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled result beat must hold its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // One character is decoded at a time.
  a_in_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  // A result never appears in the cycle right after a character arrives.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(m_axis_tvalid))
    else $error("result beat raised too early");

  // The padding bits of a result beat are always zero.
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
    else $error("result padding not zero");

endmodule

bind postfix_expression_evaluator_top pfx_checker u_pfx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RAND_ITEMS = 1550;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic        bad_symbol;
    logic        stack_overflow;
    logic        divide_by_zero;
    logic [31:0] value;
  } eval_result_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic        last;
    logic        fixed_exp;
    logic [31:0] value;
    logic        div0;
    logic        ovf;
    logic        bad;
  } char_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  wire char_fire   = s_axis_tvalid && s_axis_tready;
  wire result_fire = m_axis_tvalid && m_axis_tready;

  char_beat_t   offered = '0;
  eval_result_t pending_results [$];
  int unsigned  chars_taken = 0;
  int unsigned  mismatches = 0;
  int unsigned  rand_items = 0;
  int unsigned  burst_left = 0;

  logic signed [31:0] opnd_stack [DEPTH];
  int unsigned        opnd_count = 0;
  logic               sticky_div0 = 1'b0;
  logic               sticky_ovf = 1'b0;
  logic               sticky_bad = 1'b0;

  logic [7:0] op_chars [4] = '{pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS, pfx_pkg::CH_STAR,
                               pfx_pkg::CH_SLASH};

  // Columns: symbol, last, result typed in, value, divide_by_zero, overflow, bad.
  char_beat_t dir_tab [25] = '{
    '{pfx_pkg::CH_PLUS,        1'b1, 1'b1, 32'h0000_0000,    1'b0, 1'b0, 1'b0},
    '{8'hFF,                   1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_NINE,        1'b1, 1'b1, 32'h0009_0000,    1'b0, 1'b0, 1'b1},
    '{pfx_pkg::CH_ZERO + 8'd5, 1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_ZERO,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_SLASH,       1'b1, 1'b1, 32'h0000_0000,    1'b1, 1'b0, 1'b0},
    '{pfx_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_MINUS,       1'b1, 1'b1, 32'h0004_0000,    1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_ZERO,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{8'h00,                   1'b1, 1'b1, 32'h0000_0000,    1'b0, 1'b0, 1'b1},
    '{pfx_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_STAR,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_SLASH,       1'b1, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_NINE,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_NINE,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_STAR,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_NINE,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_STAR,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_NINE,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_STAR,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_NINE,        1'b0, 1'b0, 32'h0,            1'b0, 1'b0, 1'b0},
    '{pfx_pkg::CH_STAR,        1'b1, 1'b1, pfx_pkg::Q_MAX,   1'b0, 1'b0, 1'b0}
  };

  postfix_expression_evaluator_top #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp_q(input longint v);
    if (v > longint'(signed'(pfx_pkg::Q_MAX))) return pfx_pkg::Q_MAX;
    if (v < longint'(signed'(pfx_pkg::Q_MIN))) return pfx_pkg::Q_MIN;
    return v[31:0];
  endfunction

  function automatic void push_opnd(input logic signed [31:0] v);
    if (opnd_count >= DEPTH) begin
      sticky_ovf = 1'b1;
    end else begin
      opnd_stack[opnd_count] = v;
      opnd_count++;
    end
  endfunction

  function automatic logic signed [31:0] pop_opnd();
    if (opnd_count == 0) return 32'sd0;
    opnd_count--;
    return opnd_stack[opnd_count];
  endfunction

  function automatic bit eval_char(input logic [7:0] sym, input logic last,
                                   output eval_result_t res);
    logic signed [31:0] rhs;
    logic signed [31:0] lhs;
    res = '0;
    if (sym >= pfx_pkg::CH_ZERO && sym <= pfx_pkg::CH_NINE) begin
      push_opnd(32'(sym - pfx_pkg::CH_ZERO) << 16);
    end else if (sym inside {pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS, pfx_pkg::CH_STAR,
                             pfx_pkg::CH_SLASH}) begin
      rhs = pop_opnd();
      lhs = pop_opnd();
      case (sym)
        pfx_pkg::CH_PLUS:  push_opnd(clamp_q(longint'(lhs) + longint'(rhs)));
        pfx_pkg::CH_MINUS: push_opnd(clamp_q(longint'(lhs) - longint'(rhs)));
        pfx_pkg::CH_STAR:  push_opnd(clamp_q((longint'(lhs) * longint'(rhs)) >>> 16));
        default: begin
          if (rhs == 0) begin
            sticky_div0 = 1'b1;
            push_opnd(32'sd0);
          end else begin
            push_opnd(clamp_q((longint'(lhs) <<< 16) / longint'(rhs)));
          end
        end
      endcase
    end else begin
      sticky_bad = 1'b1;
    end
    if (!last) return 1'b0;
    res.value          = pop_opnd();
    res.divide_by_zero = sticky_div0;
    res.stack_overflow = sticky_ovf;
    res.bad_symbol     = sticky_bad;
    opnd_count  = 0;
    sticky_div0 = 1'b0;
    sticky_ovf  = 1'b0;
    sticky_bad  = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    eval_result_t got;
    eval_result_t want;
    eval_result_t calc;
    if (result_fire) begin
      got = m_axis_tdata[34:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: value %h dz %b ov %b bad %b", got.value,
                   got.divide_by_zero, got.stack_overflow, got.bad_symbol);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value || got.divide_by_zero !== want.divide_by_zero ||
            got.stack_overflow !== want.stack_overflow ||
            got.bad_symbol !== want.bad_symbol) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected %h/%b%b%b got %h/%b%b%b", want.value,
                     want.divide_by_zero, want.stack_overflow, want.bad_symbol,
                     got.value, got.divide_by_zero, got.stack_overflow, got.bad_symbol);
          end
        end
      end
    end
    if (char_fire) begin
      chars_taken++;
      if (eval_char(offered.symbol, offered.last, calc)) begin
        if (offered.fixed_exp) begin
          calc.value          = offered.value;
          calc.divide_by_zero = offered.div0;
          calc.stack_overflow = offered.ovf;
          calc.bad_symbol     = offered.bad;
        end
        pending_results.push_back(calc);
      end
    end
  end

  // The sink follows a rotating stall pattern and twice holds off for a long stretch.
  initial begin : result_sink
    logic [15:0] pattern;
    int unsigned cycle;
    int unsigned holds_done;
    pattern = '1;
    cycle = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done < 2 && chars_taken >= (holds_done + 1) * 500) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_done++;
      end else begin
        if (cycle % 48 == 0) begin
          pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
        end
        m_axis_tready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
        cycle++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (char_fire || result_fire) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_beat(input char_beat_t b);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5))
        @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b.symbol;
    s_axis_tlast  <= b.last;
    offered       <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed expressions with random content; some build a tall stack,
  // some favor large operands, and the rest are noise or broken sequences.
  task automatic plan_expression();
    int unsigned kind;
    int unsigned n_ops;
    int unsigned ops;
    int unsigned depth;
    int unsigned i;
    logic [7:0]  syms [$];
    char_beat_t  b;
    kind = $urandom_range(0, 9);
    n_ops = $urandom_range(0, 7);
    ops = 0;
    depth = 0;
    if (kind == 7) begin
      repeat ($urandom_range(1, 6)) syms.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (kind == 6) begin
        repeat ($urandom_range(14, 20)) begin
          syms.push_back(pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          if (depth < DEPTH) depth++;
        end
      end
      while (ops < n_ops || depth != 1) begin
        if (kind == 8 && $urandom_range(0, 5) == 0) begin
          syms.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 8 && $urandom_range(0, 7) == 0) begin
          syms.push_back(op_chars[$urandom_range(0, 3)]);
        end
        if (depth < 2 || (ops < n_ops && depth < 6 && $urandom_range(0, 1) == 1)) begin
          syms.push_back(pfx_pkg::CH_ZERO + 8'(kind == 9 ? $urandom_range(7, 9)
                                                         : $urandom_range(0, 9)));
          depth++;
        end else begin
          if (kind == 9 && $urandom_range(0, 1) == 1) syms.push_back(pfx_pkg::CH_STAR);
          else syms.push_back(op_chars[$urandom_range(0, 3)]);
          depth--;
          ops++;
        end
      end
    end
    for (i = 0; i < syms.size(); i++) begin
      b = '0;
      b.symbol = syms[i];
      b.last = (i == syms.size() - 1);
      rand_items++;
      send_beat(b);
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    bit paused;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (i = 0; i < $size(dir_tab); i++) send_beat(dir_tab[i]);
    drain_results();
    while (rand_items < RAND_ITEMS) begin
      if (!paused && rand_items >= RAND_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      plan_expression();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
